// ===== hw/rtl/qsre_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsre_pkg
// Shared constants, sequencer state type and record field helpers.
// ----------------------------------------------------------------------------
package qsre_pkg;

    localparam int QSRE_MAX_RECORDS   = 64;
    localparam int QSRE_STACK_ENTRIES = 30;
    localparam int QSRE_RECORD_BITS   = 48;
    localparam int QSRE_SHORT_RANGE   = 8;
    localparam int QSRE_KEY_W         = 32;
    localparam int QSRE_TAG_W         = 16;
    localparam int QSRE_DATA_W        = 48;

    typedef enum logic [5:0] {
        S_LOAD,
        S_RANGE,
        S_SEL_START,
        S_SEL_BIG,
        S_SEL_CMP,
        S_SEL_SW1,
        S_SEL_SW2,
        S_MED0,
        S_MED1,
        S_MED2,
        S_MED3,
        S_MED4,
        S_MED5,
        S_MED6,
        S_MED7,
        S_LA,
        S_LA_CMP,
        S_LB,
        S_LB_CMP,
        S_HA,
        S_HA_CMP,
        S_CHK,
        S_SW0,
        S_SW1,
        S_SW2,
        S_SW3,
        S_FA,
        S_FA_CMP,
        S_FB,
        S_FB_CMP,
        S_DEC,
        S_POP,
        S_POP_W,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_HOLD
    } t_state;

    // record layout: key above a 16-bit tag
    function automatic logic [QSRE_KEY_W-1:0] rec_key(input logic [63:0] rec);
        rec_key = rec[47:16];
    endfunction

    function automatic logic [QSRE_TAG_W-1:0] rec_tag(input logic [63:0] rec);
        rec_tag = rec[15:0];
    endfunction

endpackage

// ===== hw/rtl/qsre_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsre_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module qsre_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 48,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/quicksort_record_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quicksort_record_engine_unit
// Loads keyed records, sorts them by quicksort in place, streams them out.
// ----------------------------------------------------------------------------
// Usage:
//   Records enter on the s_axis channel, one beat per record, one per cycle.
//   s_axis_tlast marks the final record of a set. Records beyond MAX_RECORDS
//   are dropped, but a dropped beat with tlast still closes the set.
//   After the closing beat s_axis_tready stays low while the set is sorted in
//   the record RAM and then sent on m_axis in ascending key order, the final
//   beat carrying m_axis_tlast. Then the block takes a new set.
// Sort and drain:
//   Sorting is paced by the record RAM reads; a swap in a partition reads
//   both records and writes them back. Ranges of eight or fewer records
//   go through a selection pass. Each output beat is read from the record
//   RAM, loaded into the output register and held there until taken.
// Reset: synchronous, active low; clears the record count and range stack
//   level and returns to loading. RAM contents are not cleared.
// Stall: a result waits in the output register while m_axis_tready is low;
//   the sequencer holds until it is taken.
// ----------------------------------------------------------------------------
module quicksort_record_engine_unit #(
    parameter int MAX_RECORDS   = qsre_pkg::QSRE_MAX_RECORDS,
    parameter int STACK_ENTRIES = qsre_pkg::QSRE_STACK_ENTRIES,
    parameter int RECORD_BITS   = qsre_pkg::QSRE_RECORD_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [qsre_pkg::QSRE_DATA_W-1:0] s_axis_tdata,  // [31:0] in_key, [47:32] in_tag
    input  logic                             s_axis_tlast,  // in_last
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [qsre_pkg::QSRE_DATA_W-1:0] m_axis_tdata,  // [31:0] out_key, [47:32] out_tag
    output logic                             m_axis_tlast   // out_last
);

    import qsre_pkg::*;

    localparam int AW   = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int IW   = ($clog2(MAX_RECORDS) + 2 > 5) ? $clog2(MAX_RECORDS) + 2 : 5;
    localparam int CW   = $clog2(MAX_RECORDS + 1);
    localparam int SAW  = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;
    localparam int SPW  = $clog2(STACK_ENTRIES + 1);
    localparam int SW   = 2 * AW;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    t_state                  r_state, n_state;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic [CW-1:0]           r_oidx, n_oidx;
    logic [SPW-1:0]          r_sp, n_sp;
    logic signed [IW-1:0]    r_lo, n_lo, r_hi, n_hi;      // current range
    logic signed [IW-1:0]    r_low, n_low, r_high, n_high;
    logic signed [IW-1:0]    r_mid, n_mid;
    logic signed [IW-1:0]    r_end, n_end, r_item, n_item, r_big, n_big;
    logic [QSRE_KEY_W-1:0]   r_pkey, n_pkey;              // pivot key
    logic [QSRE_KEY_W-1:0]   r_big_key, n_big_key;
    logic [RECORD_BITS-1:0]  r_rec_a, n_rec_a, r_rec_b, n_rec_b, r_rec_c, n_rec_c;
    logic                    r_out_valid, n_out_valid;
    logic                    r_out_last, n_out_last;
    logic [QSRE_KEY_W-1:0]   r_out_key, n_out_key;
    logic [QSRE_TAG_W-1:0]   r_out_tag, n_out_tag;

    // RAM ports
    logic                    rec_we;
    logic [AW-1:0]           rec_waddr, rec_raddr;
    logic [RECORD_BITS-1:0]  rec_wdata, rec_rdata;
    logic                    stk_we;
    logic [SAW-1:0]          stk_waddr, stk_raddr;
    logic [SW-1:0]           stk_wdata, stk_rdata;

    // ------------------------------------------------------------------
    // shared terms
    // ------------------------------------------------------------------
    logic                    w_in_acc, w_out_acc, w_room, w_push, w_left_big;
    logic [CW-1:0]           w_cnt_after, w_oidx_inc;
    logic signed [IW-1:0]    w_low_inc, w_high_dec, w_high_inc, w_item_inc, w_end_dec;
    logic signed [IW-1:0]    w_size, w_mid_calc;
    logic [SPW-1:0]          w_sp_dec;
    logic [QSRE_KEY_W-1:0]   w_rd_key, w_key_a, w_key_b, w_key_c;

    assign w_in_acc    = s_axis_tvalid && s_axis_tready;
    assign w_out_acc   = r_out_valid && m_axis_tready;
    assign w_room      = (r_cnt < CW'(MAX_RECORDS));
    assign w_cnt_after = w_room ? CW'(r_cnt + 1'b1) : r_cnt;
    assign w_oidx_inc  = CW'(r_oidx + 1'b1);
    assign w_low_inc   = IW'(r_low + 1);
    assign w_high_dec  = IW'(r_high - 1);
    assign w_high_inc  = IW'(r_high + 1);
    assign w_item_inc  = IW'(r_item + 1);
    assign w_end_dec   = IW'(r_end - 1);
    assign w_size      = IW'(r_hi - r_lo + 1);
    assign w_mid_calc  = IW'(r_lo + (w_size >>> 1));
    assign w_sp_dec    = SPW'(r_sp - 1'b1);
    assign w_rd_key    = rec_key(64'(rec_rdata));
    assign w_key_a     = rec_key(64'(r_rec_a));
    assign w_key_b     = rec_key(64'(r_rec_b));
    assign w_key_c     = rec_key(64'(r_rec_c));
    // larger part of the split goes on the stack
    assign w_left_big  = (r_high - r_lo >= r_hi - r_low);
    assign w_push      = w_left_big ? (r_lo < r_high) : (r_low < r_hi);

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (w_in_acc && s_axis_tlast) begin
                    n_state = (w_cnt_after >= CW'(2)) ? S_RANGE : S_OUT_RD;
                end
            end
            S_RANGE: begin
                n_state = (w_size <= $signed(IW'(QSRE_SHORT_RANGE))) ? S_SEL_START : S_MED0;
            end
            S_SEL_START: n_state = (r_end > r_lo) ? S_SEL_BIG : S_POP;
            S_SEL_BIG:   n_state = S_SEL_CMP;
            S_SEL_CMP:   n_state = (r_item < r_end) ? S_SEL_CMP : S_SEL_SW1;
            S_SEL_SW1:   n_state = S_SEL_SW2;
            S_SEL_SW2:   n_state = S_SEL_START;
            S_MED0:      n_state = S_MED1;
            S_MED1:      n_state = S_MED2;
            S_MED2:      n_state = S_MED3;
            S_MED3:      n_state = S_MED4;
            S_MED4:      n_state = S_MED5;
            S_MED5:      n_state = S_MED6;
            S_MED6:      n_state = S_MED7;
            S_MED7:      n_state = S_LA;
            S_LA: begin
                if (r_mid > r_low) begin
                    n_state = (w_low_inc < r_mid) ? S_LA_CMP : S_LB;
                end else begin
                    n_state = S_LB;
                end
            end
            S_LA_CMP: begin
                if (w_rd_key <= r_pkey && w_low_inc < r_mid) begin
                    n_state = S_LA_CMP;
                end else begin
                    n_state = S_LB;
                end
            end
            S_LB: begin
                if (r_mid <= r_low) begin
                    n_state = (w_low_inc <= r_hi) ? S_LB_CMP : S_HA;
                end else begin
                    n_state = S_HA;
                end
            end
            S_LB_CMP: begin
                if (w_rd_key <= r_pkey && w_low_inc <= r_hi) begin
                    n_state = S_LB_CMP;
                end else begin
                    n_state = S_HA;
                end
            end
            S_HA:        n_state = (w_high_dec > r_mid) ? S_HA_CMP : S_CHK;
            S_HA_CMP: begin
                if (w_rd_key > r_pkey && w_high_dec > r_mid) begin
                    n_state = S_HA_CMP;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_CHK:       n_state = (r_low > r_high) ? S_FA : S_SW0;
            S_SW0:       n_state = S_SW1;
            S_SW1:       n_state = S_SW2;
            S_SW2:       n_state = S_SW3;
            S_SW3:       n_state = S_LA;
            S_FA: begin
                if (r_mid < r_high) begin
                    n_state = (w_high_dec > r_mid) ? S_FA_CMP : S_FB;
                end else begin
                    n_state = S_FB;
                end
            end
            S_FA_CMP: begin
                if (w_rd_key == r_pkey && w_high_dec > r_mid) begin
                    n_state = S_FA_CMP;
                end else begin
                    n_state = S_FB;
                end
            end
            S_FB: begin
                if (r_mid >= r_high) begin
                    n_state = (w_high_dec > r_lo) ? S_FB_CMP : S_DEC;
                end else begin
                    n_state = S_DEC;
                end
            end
            S_FB_CMP: begin
                if (w_rd_key == r_pkey && w_high_dec > r_lo) begin
                    n_state = S_FB_CMP;
                end else begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (w_left_big) begin
                    n_state = (r_low < r_hi) ? S_RANGE : S_POP;
                end else begin
                    n_state = (r_lo < r_high) ? S_RANGE : S_POP;
                end
            end
            S_POP:       n_state = (r_sp == '0) ? S_OUT_RD : S_POP_W;
            S_POP_W:     n_state = S_RANGE;
            S_OUT_RD:    n_state = S_OUT_LD;
            S_OUT_LD:    n_state = S_OUT_HOLD;
            S_OUT_HOLD: begin
                if (w_out_acc) begin
                    n_state = r_out_last ? S_LOAD : S_OUT_LD;
                end
            end
            default:     n_state = S_LOAD;
        endcase
    end

    // ------------------------------------------------------------------
    // outputs: RAM controls and datapath updates
    // ------------------------------------------------------------------
    always_comb begin
        rec_we      = 1'b0;
        rec_waddr   = r_lo[AW-1:0];
        rec_wdata   = r_rec_a;
        rec_raddr   = r_lo[AW-1:0];
        stk_we      = 1'b0;
        stk_waddr   = r_sp[SAW-1:0];
        stk_wdata   = {r_high[AW-1:0], r_lo[AW-1:0]};
        stk_raddr   = w_sp_dec[SAW-1:0];
        n_cnt       = r_cnt;
        n_oidx      = r_oidx;
        n_sp        = r_sp;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_low       = r_low;
        n_high      = r_high;
        n_mid       = r_mid;
        n_end       = r_end;
        n_item      = r_item;
        n_big       = r_big;
        n_pkey      = r_pkey;
        n_big_key   = r_big_key;
        n_rec_a     = r_rec_a;
        n_rec_b     = r_rec_b;
        n_rec_c     = r_rec_c;
        n_out_valid = r_out_valid;
        n_out_last  = r_out_last;
        n_out_key   = r_out_key;
        n_out_tag   = r_out_tag;
        s_axis_tready = (r_state == S_LOAD);

        unique case (r_state)
            S_LOAD: begin
                rec_waddr = r_cnt[AW-1:0];
                rec_wdata = RECORD_BITS'({s_axis_tdata[31:0], s_axis_tdata[47:32]});
                if (w_in_acc) begin
                    rec_we = w_room;
                    n_cnt  = w_cnt_after;
                    if (s_axis_tlast) begin
                        n_lo   = '0;
                        n_hi   = IW'($signed(IW'(w_cnt_after)) - 1);
                        n_sp   = '0;
                        n_oidx = '0;
                    end
                end
            end
            S_RANGE: begin
                n_end = r_hi;
                n_mid = w_mid_calc;
            end
            // selection sort: carry the maximum to the end of the range
            S_SEL_START: begin
                n_big  = r_lo;
                n_item = IW'(r_lo + 1);
            end
            S_SEL_BIG: begin
                rec_raddr = r_item[AW-1:0];
                n_big_key = w_rd_key;
                n_rec_b   = rec_rdata;
            end
            S_SEL_CMP: begin
                rec_raddr = w_item_inc[AW-1:0];
                if (w_rd_key > r_big_key) begin
                    n_big     = r_item;
                    n_big_key = w_rd_key;
                    n_rec_b   = rec_rdata;
                end
                if (r_item < r_end) begin
                    n_item = w_item_inc;
                end else begin
                    n_rec_a = rec_rdata;
                end
            end
            S_SEL_SW1: begin
                rec_we    = 1'b1;
                rec_waddr = r_big[AW-1:0];
                rec_wdata = r_rec_a;
            end
            S_SEL_SW2: begin
                rec_we    = 1'b1;
                rec_waddr = r_end[AW-1:0];
                rec_wdata = r_rec_b;
                n_end     = w_end_dec;
            end
            // median of three on lo, mid, hi
            S_MED0: rec_raddr = r_lo[AW-1:0];
            S_MED1: begin
                rec_raddr = r_mid[AW-1:0];
                n_rec_a   = rec_rdata;
            end
            S_MED2: begin
                rec_raddr = r_hi[AW-1:0];
                n_rec_b   = rec_rdata;
            end
            S_MED3: begin
                n_rec_c = rec_rdata;
                if (w_key_a > w_key_b) begin
                    n_rec_a = r_rec_b;
                    n_rec_b = r_rec_a;
                end
            end
            S_MED4: begin
                if (w_key_a > w_key_c) begin
                    n_rec_a = r_rec_c;
                    n_rec_c = r_rec_a;
                end
            end
            S_MED5: begin
                rec_we    = 1'b1;
                rec_waddr = r_lo[AW-1:0];
                rec_wdata = r_rec_a;
                if (w_key_b > w_key_c) begin
                    n_rec_b = r_rec_c;
                    n_rec_c = r_rec_b;
                end
            end
            S_MED6: begin
                rec_we    = 1'b1;
                rec_waddr = r_mid[AW-1:0];
                rec_wdata = r_rec_b;
                n_pkey    = w_key_b;
                n_low     = r_lo;
                n_high    = r_hi;
            end
            S_MED7: begin
                rec_we    = 1'b1;
                rec_waddr = r_hi[AW-1:0];
                rec_wdata = r_rec_c;
            end
            // partition scans
            S_LA: begin
                rec_raddr = w_low_inc[AW-1:0];
                if (r_mid > r_low) begin
                    n_low = w_low_inc;
                end
            end
            S_LA_CMP: begin
                rec_raddr = w_low_inc[AW-1:0];
                if (w_rd_key <= r_pkey) begin
                    n_low = w_low_inc;
                end
            end
            S_LB: begin
                rec_raddr = w_low_inc[AW-1:0];
                if (r_mid <= r_low) begin
                    n_low = w_low_inc;
                end
            end
            S_LB_CMP: begin
                rec_raddr = w_low_inc[AW-1:0];
                if (w_rd_key <= r_pkey) begin
                    n_low = w_low_inc;
                end
            end
            S_HA: begin
                rec_raddr = w_high_dec[AW-1:0];
                n_high    = w_high_dec;
            end
            S_HA_CMP: begin
                rec_raddr = w_high_dec[AW-1:0];
                if (w_rd_key > r_pkey) begin
                    n_high = w_high_dec;
                end
            end
            S_CHK: begin
                if (r_low > r_high) begin
                    n_high = w_high_inc;
                end
            end
            S_SW0: rec_raddr = r_low[AW-1:0];
            S_SW1: begin
                rec_raddr = r_high[AW-1:0];
                n_rec_a   = rec_rdata;
            end
            S_SW2: begin
                rec_we    = 1'b1;
                rec_waddr = r_low[AW-1:0];
                rec_wdata = rec_rdata;
            end
            S_SW3: begin
                rec_we    = 1'b1;
                rec_waddr = r_high[AW-1:0];
                rec_wdata = r_rec_a;
                // pivot identity follows its record
                if (r_mid == r_high) begin
                    n_mid = r_low;
                end
            end
            // skip records equal to the pivot
            S_FA: begin
                rec_raddr = w_high_dec[AW-1:0];
                if (r_mid < r_high) begin
                    n_high = w_high_dec;
                end
            end
            S_FA_CMP: begin
                rec_raddr = w_high_dec[AW-1:0];
                if (w_rd_key == r_pkey) begin
                    n_high = w_high_dec;
                end
            end
            S_FB: begin
                rec_raddr = w_high_dec[AW-1:0];
                if (r_mid >= r_high) begin
                    n_high = w_high_dec;
                end
            end
            S_FB_CMP: begin
                rec_raddr = w_high_dec[AW-1:0];
                if (w_rd_key == r_pkey) begin
                    n_high = w_high_dec;
                end
            end
            S_DEC: begin
                stk_we    = w_push && (r_sp < SPW'(STACK_ENTRIES));
                stk_wdata = w_left_big ? {r_high[AW-1:0], r_lo[AW-1:0]}
                                       : {r_hi[AW-1:0], r_low[AW-1:0]};
                if (stk_we) begin
                    n_sp = SPW'(r_sp + 1'b1);
                end
                if (w_left_big) begin
                    n_lo = r_low;
                end else begin
                    n_hi = r_high;
                end
            end
            S_POP: begin
                n_oidx = '0;
                if (r_sp != '0) begin
                    n_sp = w_sp_dec;
                end
            end
            S_POP_W: begin
                n_lo = $signed(IW'(stk_rdata[AW-1:0]));
                n_hi = $signed(IW'(stk_rdata[SW-1:AW]));
            end
            // drain in index order
            S_OUT_RD: rec_raddr = r_oidx[AW-1:0];
            S_OUT_LD: begin
                n_out_valid = 1'b1;
                n_out_key   = rec_key(64'(rec_rdata));
                n_out_tag   = rec_tag(64'(rec_rdata));
                n_out_last  = (w_oidx_inc == r_cnt);
            end
            S_OUT_HOLD: begin
                rec_raddr = w_oidx_inc[AW-1:0];
                if (w_out_acc) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_cnt = '0;
                    end else begin
                        n_oidx = w_oidx_inc;
                    end
                end
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // register update
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_cnt       <= '0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
            r_lo        <= '0;
            r_hi        <= '0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_sp        <= n_sp;
            r_out_valid <= n_out_valid;
            r_lo        <= n_lo;
            r_hi        <= n_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oidx     <= n_oidx;
        r_low      <= n_low;
        r_high     <= n_high;
        r_mid      <= n_mid;
        r_end      <= n_end;
        r_item     <= n_item;
        r_big      <= n_big;
        r_pkey     <= n_pkey;
        r_big_key  <= n_big_key;
        r_rec_a    <= n_rec_a;
        r_rec_b    <= n_rec_b;
        r_rec_c    <= n_rec_c;
        r_out_last <= n_out_last;
        r_out_key  <= n_out_key;
        r_out_tag  <= n_out_tag;
    end

    // ------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------
    qsre_ram #(
        .DEPTH (MAX_RECORDS),
        .WIDTH (RECORD_BITS)
    ) u_rec_ram (
        .i_clk   (i_clk),
        .i_we    (rec_we),
        .i_waddr (rec_waddr),
        .i_wdata (rec_wdata),
        .i_raddr (rec_raddr),
        .o_rdata (rec_rdata)
    );

    qsre_ram #(
        .DEPTH (STACK_ENTRIES),
        .WIDTH (SW)
    ) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_tag, r_out_key};
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_out_valid && s_axis_tready))
        else $error("input taken while a result is pending");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(STACK_ENTRIES))
        else $error("range stack level out of bounds");

    a_range_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RANGE) |-> (r_lo < r_hi))
        else $error("empty range scheduled");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_RECORDS))
        else $error("record count beyond capacity");
`endif

endmodule
